### hdl/hbtk_pkg.sv
package hbtk_pkg;
   localparam int NUM_BINS_DEF  = 500;
   localparam int MAX_ITEMS_DEF = 4096;
   localparam int TAG_WIDTH_DEF = 16;
   localparam int OUT_TAG_W   = 16;
   localparam int SCORE_W     = 17;
   localparam int COUNT_W     = 13;
   localparam logic [SCORE_W-1:0] SCORE_ONE = 17'd65536;
   localparam logic [COUNT_W-1:0] ALLOWED_RESET = 13'd4096;
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_NEXT = 1'b1;

   typedef struct packed {
      logic                 cmd;
      logic [15:0]          item_tag;
      logic [SCORE_W-1:0]   score;
   } req_word_type;

   typedef struct packed {
      logic [OUT_TAG_W-1:0] out_tag;
      logic [SCORE_W-1:0]   out_score;
      logic                 is_summary;
      logic                 all_afforded;
      logic [COUNT_W-1:0]   selected_total;
      logic [SCORE_W-1:0]   min_score;
      logic                 overflowed;
   } rsp_word_type;
endpackage

### hdl/hbtk_req_if.sv
interface hbtk_req_if;
   import hbtk_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### hdl/hbtk_rsp_if.sv
interface hbtk_rsp_if;
   import hbtk_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### hdl/histogram_bin_top_k_select_core.sv
// A load steps through bin read, bin re-read, and item and bin write-back.
// A next word returns an item once the scan has read each bin it steps down to, or a
// summary; when all are afforded the summary is sent without a scan.
// Throughput: one word in flight; the next word waits until the result word is taken.
// After a summary a clearing pass over all NUM_BINS bins empties the bin table. Reset
// (synchronous, active high) starts that same pass; no word is accepted until it ends.
module histogram_bin_top_k_select_core #(
   parameter int NUM_BINS  = hbtk_pkg::NUM_BINS_DEF,
   parameter int MAX_ITEMS = hbtk_pkg::MAX_ITEMS_DEF,
   parameter int TAG_WIDTH = hbtk_pkg::TAG_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   hbtk_req_if.sink                      req,
   hbtk_rsp_if.source                    rsp,
   input  logic                          csr_we,
   input  logic [hbtk_pkg::COUNT_W-1:0]  csr_wdata
);
   import hbtk_pkg::*;

   localparam int BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int TW = (TAG_WIDTH < 16) ? TAG_WIDTH : 16;
   localparam logic [BW:0] NB = (BW+1)'(NUM_BINS);
   localparam logic [BW-1:0] TOP_BIN = BW'(NUM_BINS - 1);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

   // Bin table: count and head in one memory word; store in another.
   logic [CW+IW-1:0] bin_mem [NUM_BINS];
   logic [TW+SCORE_W+IW-1:0] item_mem [MAX_ITEMS];
   logic [CW+IW-1:0] bin_rd;
   logic [TW+SCORE_W+IW-1:0] item_rd;
   logic bin_we, item_we;
   logic [BW-1:0] bin_wa, bin_ra;
   logic [CW+IW-1:0] bin_wd;
   logic [IW-1:0] item_wa, item_ra;
   logic [TW+SCORE_W+IW-1:0] item_wd;

   always_ff @(posedge clock) begin
      if (bin_we) bin_mem[bin_wa] <= bin_wd;
      bin_rd <= bin_mem[bin_ra];
      if (item_we) item_mem[item_wa] <= item_wd;
      item_rd <= item_mem[item_ra];
   end

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_LD_RD, S_LD_WR, S_SCAN_RD, S_SCAN,
      S_ITEM_RD, S_ITEM, S_OUT
   } state_type;

   state_type state_ff;
   logic [COUNT_W-1:0] allowed_ff;
   logic [CW-1:0] loaded_ff, picked_ff, left_ff;
   logic drop_ff, selecting_ff;
   logic [BW-1:0] ptr_ff;
   logic [BW:0] cursor_ff;
   logic [IW-1:0] item_ff;
   logic [SCORE_W-1:0] min_ff;
   logic [TW-1:0] tag_ff;
   logic [SCORE_W-1:0] score_ff;
   logic rsp_valid_ff;
   rsp_word_type rsp_ff;

   // Bin of a score: floor(score * 2N / 65536) - N, clamped.
   logic [SCORE_W+BW+1:0] prod;
   logic [BW+2:0] raw_bin;
   logic [BW-1:0] load_bin;
   always_comb begin
      prod = (SCORE_W+BW+2)'(req.data.score) * (SCORE_W+BW+2)'(2*NUM_BINS);
      raw_bin = (BW+3)'(prod >> 16);
      if (raw_bin < (BW+3)'(NUM_BINS)) load_bin = '0;
      else if (raw_bin - (BW+3)'(NUM_BINS) > (BW+3)'(NUM_BINS-1)) load_bin = TOP_BIN;
      else load_bin = BW'(raw_bin - (BW+3)'(NUM_BINS));
   end

   logic [CW-1:0] rd_count;
   logic [IW-1:0] rd_head;
   assign rd_count = bin_rd[CW+IW-1:IW];
   assign rd_head  = bin_rd[IW-1:0];

   logic accept;
   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept = req.valid && req.ready;

   always_comb begin
      bin_we = 1'b0; bin_wa = ptr_ff; bin_wd = '0;
      bin_ra = ptr_ff;
      item_we = 1'b0; item_wa = loaded_ff[IW-1:0];
      item_wd = {tag_ff, score_ff, rd_head};
      item_ra = item_ff;
      case (state_ff)
         S_CLEAR: begin bin_we = 1'b1; end
         S_IDLE: bin_ra = load_bin;
         // The scan reads the bin below the cursor so that it is ready in S_SCAN.
         S_SCAN_RD: bin_ra = BW'(cursor_ff - (BW+1)'(1));
         S_LD_WR: begin
            item_we = 1'b1;
            bin_we = 1'b1;
            bin_wd = {rd_count + CW'(1), loaded_ff[IW-1:0]};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ptr_ff <= '0;
         allowed_ff <= ALLOWED_RESET;
         rsp_valid_ff <= 1'b0;
         loaded_ff <= '0; drop_ff <= 1'b0; selecting_ff <= 1'b0;
         picked_ff <= '0; left_ff <= '0; min_ff <= SCORE_ONE;
         cursor_ff <= '0; item_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         if (csr_we && !selecting_ff) allowed_ff <= csr_wdata;
         case (state_ff)
            S_CLEAR: begin
               if (ptr_ff == TOP_BIN) begin
                  state_ff <= S_IDLE;
                  ptr_ff <= '0;
               end else ptr_ff <= ptr_ff + BW'(1);
            end
            S_IDLE: if (accept) begin
               if (req.data.cmd == CMD_LOAD) begin
                  if (selecting_ff) ;
                  else if (loaded_ff >= MAX_C) drop_ff <= 1'b1;
                  else begin
                     tag_ff <= TW'(req.data.item_tag);
                     score_ff <= req.data.score;
                     ptr_ff <= load_bin;
                     state_ff <= S_LD_RD;
                  end
               end else if (!selecting_ff) begin
                  if ({{(32-CW){1'b0}}, loaded_ff} <= {19'd0, allowed_ff}) begin
                     rsp_ff <= '{out_tag: '0, out_score: '0, is_summary: 1'b1,
                        all_afforded: 1'b1, selected_total: COUNT_W'(loaded_ff),
                        min_score: SCORE_ONE, overflowed: drop_ff};
                     state_ff <= S_OUT;
                  end else begin
                     selecting_ff <= 1'b1;
                     cursor_ff <= NB;
                     left_ff <= '0; picked_ff <= '0; min_ff <= SCORE_ONE;
                     state_ff <= S_SCAN_RD;
                  end
               end else begin
                  state_ff <= S_SCAN_RD;
               end
            end
            S_LD_RD: state_ff <= S_LD_WR;
            S_LD_WR: begin
               loaded_ff <= loaded_ff + CW'(1);
               state_ff <= S_IDLE;
            end
            S_SCAN_RD: begin
               if ({{(32-CW){1'b0}}, picked_ff} >= {19'd0, allowed_ff}) begin
                  rsp_ff <= '{out_tag: '0, out_score: '0, is_summary: 1'b1,
                     all_afforded: 1'b0, selected_total: COUNT_W'(picked_ff),
                     min_score: min_ff, overflowed: drop_ff};
                  state_ff <= S_OUT;
               end else if (left_ff != '0) state_ff <= S_ITEM_RD;
               else if (cursor_ff == '0) begin
                  rsp_ff <= '{out_tag: '0, out_score: '0, is_summary: 1'b1,
                     all_afforded: 1'b0, selected_total: COUNT_W'(picked_ff),
                     min_score: min_ff, overflowed: drop_ff};
                  state_ff <= S_OUT;
               end else begin
                  ptr_ff <= BW'(cursor_ff - (BW+1)'(1));
                  cursor_ff <= cursor_ff - (BW+1)'(1);
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               left_ff <= rd_count;
               item_ff <= rd_head;
               state_ff <= S_SCAN_RD;
            end
            S_ITEM_RD: state_ff <= S_ITEM;
            S_ITEM: begin
               rsp_ff <= '{out_tag: OUT_TAG_W'(item_rd[TW+SCORE_W+IW-1:SCORE_W+IW]),
                  out_score: item_rd[SCORE_W+IW-1:IW], is_summary: 1'b0,
                  all_afforded: 1'b0, selected_total: '0, min_score: '0,
                  overflowed: 1'b0};
               if (item_rd[SCORE_W+IW-1:IW] < min_ff) min_ff <= item_rd[SCORE_W+IW-1:IW];
               picked_ff <= picked_ff + CW'(1);
               left_ff <= left_ff - CW'(1);
               item_ff <= item_rd[IW-1:0];
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_OUT: begin
               rsp_valid_ff <= 1'b1;
               loaded_ff <= '0; drop_ff <= 1'b0; selecting_ff <= 1'b0;
               picked_ff <= '0; left_ff <= '0; min_ff <= SCORE_ONE;
               ptr_ff <= '0;
               state_ff <= S_CLEAR;
            end
            default: state_ff <= S_CLEAR;
         endcase
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= MAX_C) else $error("loaded count beyond capacity");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("result lost");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("accept while result pending");
endmodule
